### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file; all are clocked on clk and gated by rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define HASD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define HASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hasd_pkg.sv
// types, codes and constants of the heading align settle detector
`default_nettype none

package hasd_pkg;

  // heading, error, band, stable count and tick widths
  localparam int HEADING_W = 16;
  localparam int ERROR_W   = 16;
  localparam int BAND_W    = 15;
  localparam int STABLE_W  = 8;
  localparam int TICKS_W   = 16;
  // width of the raw difference and its wrap candidates
  localparam int WRAP_W    = 19;

  // turn constants in centidegrees
  localparam logic signed [WRAP_W-1:0] HALF_TURN_CD  = 19'sd18000;
  localparam logic signed [WRAP_W-1:0] FULL_TURN_CD  = 19'sd36000;
  localparam logic signed [WRAP_W-1:0] THREE_HALF_CD = 19'sd54000;
  localparam logic signed [WRAP_W-1:0] TWO_TURN_CD   = 19'sd72000;

  // saturation limits
  localparam logic [TICKS_W-1:0]  TICKS_MAX  = 16'hFFFF;
  localparam logic [STABLE_W-1:0] STABLE_MAX = 8'hFF;

  // configuration defaults
  localparam logic [BAND_W-1:0]   ZERO_BAND_RST     = 15'd100;
  localparam logic [BAND_W-1:0]   TOLERANCE_RST     = 15'd300;
  localparam logic [STABLE_W-1:0] STABLE_NEEDED_RST = 8'd10;
  localparam logic [TICKS_W-1:0]  TIMEOUT_RST       = 16'd3000;

  localparam int CFG_DATA_W = 16;

  // configuration register index
  typedef enum logic [1:0] {
    REG_ZERO_BAND     = 2'd0,
    REG_TOLERANCE     = 2'd1,
    REG_STABLE_NEEDED = 2'd2,
    REG_TIMEOUT       = 2'd3
  } cfg_reg_t;

  // word operation
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    logic [BAND_W-1:0]   zero_band_cd;
    logic [BAND_W-1:0]   tolerance_cd;
    logic [STABLE_W-1:0] stable_needed;
    logic [TICKS_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TICKS_W-1:0]         elapsed_ticks;
    logic [STABLE_W-1:0]        stable_count;
    logic                       zero_seen;
    logic                       last_valid;
    logic signed [ERROR_W-1:0]  last_error;
  } trk_t;

  typedef struct packed {
    logic                       reached;
    logic                       error_valid;
    logic signed [ERROR_W-1:0]  hdg_err_cd;
  } res_t;

endpackage

`default_nettype wire

### rtl/hasd_eval.sv
// single-pass evaluation of one heading word against the tracker state
`default_nettype none

module hasd_eval (
  input  wire logic                             op,
  input  wire logic                             target_valid,
  input  wire logic [hasd_pkg::HEADING_W-1:0]   target_heading_cd,
  input  wire logic                             sensor_ready,
  input  wire logic [hasd_pkg::HEADING_W-1:0]   measured_heading_cd,
  input  wire hasd_pkg::cfg_t                   cfg,
  input  wire hasd_pkg::trk_t                   trk,
  output hasd_pkg::trk_t                        trk_nxt,
  output hasd_pkg::res_t                        res
);
  import hasd_pkg::*;

  logic signed [WRAP_W-1:0]  diff;
  logic signed [WRAP_W-1:0]  wrapped;
  logic signed [ERROR_W-1:0] err;
  logic [ERROR_W-1:0]        mag;
  logic                      sign_flip;
  logic                      crossed;
  logic                      zero_seen_new;
  logic [TICKS_W-1:0]        elapsed_new;
  logic [STABLE_W-1:0]       stable_new;

  // raw difference, then wrap by whole turns into -18000..17999
  always_comb begin
    diff = $signed({3'b000, target_heading_cd}) - $signed({3'b000, measured_heading_cd});
    if (diff >= THREE_HALF_CD) begin
      wrapped = diff - TWO_TURN_CD;
    end else if (diff >= HALF_TURN_CD) begin
      wrapped = diff - FULL_TURN_CD;
    end else if (diff < -THREE_HALF_CD) begin
      wrapped = diff + TWO_TURN_CD;
    end else if (diff < -HALF_TURN_CD) begin
      wrapped = diff + FULL_TURN_CD;
    end else begin
      wrapped = diff;
    end
    err = wrapped[ERROR_W-1:0];
    mag = err[ERROR_W-1] ? ERROR_W'(-err) : ERROR_W'(err);
  end

  // zero crossing, stable count and elapsed ticks
  always_comb begin
    sign_flip = trk.last_valid &&
                ((trk.last_error < 0 && err > 0) || (trk.last_error > 0 && err < 0));
    crossed       = (mag <= {1'b0, cfg.zero_band_cd}) || sign_flip;
    zero_seen_new = trk.zero_seen || crossed;
    elapsed_new   = (trk.elapsed_ticks == TICKS_MAX) ? trk.elapsed_ticks
                                                     : trk.elapsed_ticks + 1'b1;
    if (zero_seen_new && (mag <= {1'b0, cfg.tolerance_cd})) begin
      stable_new = (trk.stable_count == STABLE_MAX) ? trk.stable_count
                                                    : trk.stable_count + 1'b1;
    end else begin
      stable_new = '0;
    end
  end

  // next tracker state and result word
  always_comb begin
    trk_nxt = trk;
    res     = '0;
    if (op == OP_RESTART) begin
      trk_nxt = '0;
    end else if (!target_valid || !sensor_ready) begin
      trk_nxt.stable_count = '0;
      trk_nxt.last_valid   = 1'b0;
    end else begin
      trk_nxt.elapsed_ticks = elapsed_new;
      trk_nxt.stable_count  = stable_new;
      trk_nxt.zero_seen     = zero_seen_new;
      trk_nxt.last_valid    = 1'b1;
      trk_nxt.last_error    = err;
      res.reached           = (stable_new >= cfg.stable_needed) ||
                              (elapsed_new >= cfg.timeout_ticks);
      res.error_valid       = 1'b1;
      res.hdg_err_cd        = err;
    end
  end

endmodule

`default_nettype wire

### rtl/heading_align_settle_detector.sv
// top level: input register, tracker state, result register and config port
//
//   channel  handshake               payload
//   in       in_valid / in_stall     op, target and measured headings with valid flags
//   out      out_valid / out_stall   reached, error_valid, hdg_err_cd
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; each word waits in the input register
// and is then evaluated into the result register, which drives the out channel.
// the tracker state updates in the same edge that loads the result register.
// a stalled result holds both registers; in_stall rises only when both are full.
// rst_n clears the tracker, valid flags and loads the default config values.
`default_nettype none

`include "assert_macros.svh"

module heading_align_settle_detector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic                              in_target_valid,
  input  wire logic [hasd_pkg::HEADING_W-1:0]    in_target_heading_cd,
  input  wire logic                              in_sensor_ready,
  input  wire logic [hasd_pkg::HEADING_W-1:0]    in_measured_heading_cd,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_reached,
  output logic                                   out_error_valid,
  output logic signed [hasd_pkg::ERROR_W-1:0]    out_hdg_err_cd,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire hasd_pkg::cfg_reg_t                cfg_index,
  input  wire logic [hasd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hasd_pkg::*;

  cfg_t                  cfg_r;
  trk_t                  trk_r;
  trk_t                  trk_nxt;
  res_t                  res_nxt;
  res_t                  res_r;
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic                  s1_tvalid_r;
  logic [HEADING_W-1:0]  s1_target_r;
  logic                  s1_ready_r;
  logic [HEADING_W-1:0]  s1_measured_r;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;

  // pipeline flow control
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_band_cd  <= ZERO_BAND_RST;
      cfg_r.tolerance_cd  <= TOLERANCE_RST;
      cfg_r.stable_needed <= STABLE_NEEDED_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZERO_BAND:     cfg_r.zero_band_cd  <= cfg_data[BAND_W-1:0];
        REG_TOLERANCE:     cfg_r.tolerance_cd  <= cfg_data[BAND_W-1:0];
        REG_STABLE_NEEDED: cfg_r.stable_needed <= cfg_data[STABLE_W-1:0];
        REG_TIMEOUT:       cfg_r.timeout_ticks <= cfg_data[TICKS_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r       <= in_op;
      s1_tvalid_r   <= in_target_valid;
      s1_target_r   <= in_target_heading_cd;
      s1_ready_r    <= in_sensor_ready;
      s1_measured_r <= in_measured_heading_cd;
    end
  end

  hasd_eval u_eval (
    .op                  (s1_op_r),
    .target_valid        (s1_tvalid_r),
    .target_heading_cd   (s1_target_r),
    .sensor_ready        (s1_ready_r),
    .measured_heading_cd (s1_measured_r),
    .cfg                 (cfg_r),
    .trk                 (trk_r),
    .trk_nxt             (trk_nxt),
    .res                 (res_nxt)
  );

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= '0;
    end else if (s1_adv) begin
      trk_r <= trk_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reached     = res_r.reached;
  assign out_error_valid = res_r.error_valid;
  assign out_hdg_err_cd  = res_r.hdg_err_cd;

  // checks
  `HASD_ASSERT_ALWAYS(a_invalid_word_zero,
    !out_valid_r || res_r.error_valid || (res_r.hdg_err_cd == '0 && !res_r.reached),
    "result without error must be all zero")
  `HASD_ASSERT_ALWAYS(a_error_range,
    !out_valid_r || (res_r.hdg_err_cd >= -16'sd18000 && res_r.hdg_err_cd <= 16'sd17999),
    "heading error outside wrap range")
  `HASD_ASSERT_NEXT(a_restart_clears, s1_adv && s1_op_r == OP_RESTART, trk_r == '0, "restart did not clear tracker")
  `HASD_ASSERT_NEXT(a_elapsed_monotonic, s1_adv && s1_op_r == OP_TICK,
    trk_r.elapsed_ticks >= $past(trk_r.elapsed_ticks), "elapsed ticks went backward")

endmodule

`default_nettype wire
